// File: design/deqb_pkg.sv
// Package for the double-ended queue buffer.
// Request/response payload types, request and status codes.
// No dependencies.
package deqb_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned FIELD_DW = 32;
  localparam int unsigned OFF_W    = 4;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CNT_OUT_W = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP_OLD  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_NEW  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PEEK_NEW = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SWAP     = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]           req_type;
    logic signed [FIELD_DW-1:0] data_in;
    logic [OFF_W-1:0]           index_a;
    logic [OFF_W-1:0]           index_b;
  } req_t;

  typedef struct packed {
    logic signed [FIELD_DW-1:0] data_out;
    logic [STAT_W-1:0]          status;
    logic [CNT_OUT_W-1:0]       entry_count;
    logic                       is_empty_flag;
  } res_t;

endpackage

// File: design/deqb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module deqb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/deqb_ctrl.sv
// Queue controller: ring pointers, request decode and RAM sequencing.
// Depends on deqb_pkg; drives one deqb_ram instance.
module deqb_ctrl #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  deqb_pkg::req_t           req_i,
  output logic                     done_o,
  output deqb_pkg::res_t           res_o,
  output logic                     we_o,
  output logic [$clog2(DEPTH)-1:0] waddr_o,
  output logic [DATA_WIDTH-1:0]    wdata_o,
  output logic                     re_o,
  output logic [$clog2(DEPTH)-1:0] raddr_o,
  input  logic [DATA_WIDTH-1:0]    rdata_i
);
  import deqb_pkg::*;

  localparam int unsigned PW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned OW  = (CW > OFF_W) ? CW : OFF_W;
  localparam int unsigned SW  = OW + 1;
  localparam int unsigned XW  = (DATA_WIDTH > FIELD_DW) ? DATA_WIDTH : FIELD_DW;
  localparam int unsigned EW  = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RESP = 3'd1;
  localparam logic [2:0] S_SWB  = 3'd2;
  localparam logic [2:0] S_SWWA = 3'd3;
  localparam logic [2:0] S_SWWB = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [PW-1:0]         oldest_q, oldest_d;
  logic [CW-1:0]         count_q, count_d;
  logic [STAT_W-1:0]     status_q, status_d;
  logic                  has_data_q, has_data_d;
  logic [PW-1:0]         slot_a_q, slot_a_d;
  logic [PW-1:0]         slot_b_q, slot_b_d;
  logic [DATA_WIDTH-1:0] tmp_q;

  logic                  accept;
  logic [OW-1:0]         cnt_x, ia_x, ib_x, off_a;
  logic [PW-1:0]         slot_a, slot_b;
  logic [XW-1:0]         din_x, dout_x;
  logic [EW-1:0]         cnt_out_x;

  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [OW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  assign cnt_x = OW'(count_q);
  assign ia_x  = OW'(req_i.index_a);
  assign ib_x  = OW'(req_i.index_b);
  assign din_x = XW'($unsigned(req_i.data_in));

  always_comb begin
    case (req_i.req_type) inside
      REQ_PUSH:                  off_a = cnt_x;
      REQ_POP_NEW, REQ_PEEK_NEW: off_a = cnt_x - 1'b1;
      default:                   off_a = ia_x;
    endcase
  end

  assign slot_a = slot_of(oldest_q, off_a);
  assign slot_b = slot_of(oldest_q, ib_x);

  always_comb begin
    state_d    = state_q;
    oldest_d   = oldest_q;
    count_d    = count_q;
    status_d   = status_q;
    has_data_d = has_data_q;
    slot_a_d   = slot_a_q;
    slot_b_d   = slot_b_q;
    we_o       = 1'b0;
    waddr_o    = slot_a;
    wdata_o    = din_x[DATA_WIDTH-1:0];
    re_o       = 1'b0;
    raddr_o    = slot_a;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d   = ST_OK;
          has_data_d = 1'b0;
          state_d    = S_RESP;
          slot_a_d   = slot_a;
          slot_b_d   = slot_b;
          case (req_i.req_type) inside
            REQ_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                we_o    = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            REQ_POP_OLD: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                re_o       = 1'b1;
                raddr_o    = oldest_q;
                has_data_d = 1'b1;
                oldest_d   = (oldest_q == PW'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
                count_d    = count_q - 1'b1;
              end
            end
            REQ_POP_NEW, REQ_PEEK_NEW: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                re_o       = 1'b1;
                has_data_d = 1'b1;
                if (req_i.req_type == REQ_POP_NEW) begin
                  count_d = count_q - 1'b1;
                end
              end
            end
            REQ_READ: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (ia_x >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                re_o       = 1'b1;
                has_data_d = 1'b1;
              end
            end
            REQ_SWAP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (ia_x >= cnt_x || ib_x >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                re_o    = 1'b1;
                state_d = S_SWB;
              end
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      S_SWB: begin
        re_o    = 1'b1;
        raddr_o = slot_b_q;
        state_d = S_SWWA;
      end
      S_SWWA: begin
        we_o    = 1'b1;
        waddr_o = slot_a_q;
        wdata_o = rdata_i;
        state_d = S_SWWB;
      end
      S_SWWB: begin
        we_o    = 1'b1;
        waddr_o = slot_b_q;
        wdata_o = tmp_q;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      oldest_q   <= '0;
      count_q    <= '0;
      status_q   <= ST_OK;
      has_data_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      oldest_q   <= oldest_d;
      count_q    <= count_d;
      status_q   <= status_d;
      has_data_q <= has_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_a_q <= slot_a_d;
    slot_b_q <= slot_b_d;
    if (state_q == S_SWB) begin
      tmp_q <= rdata_i;
    end
  end

  // read data is valid in the response cycle only
  assign dout_x    = XW'(rdata_i);
  assign cnt_out_x = EW'(count_q);
  assign done_o    = (state_q == S_RESP) || (state_q == S_SWWB);

  always_comb begin
    res_o.data_out      = (state_q == S_RESP && has_data_q) ?
                          $signed(dout_x[FIELD_DW-1:0]) : '0;
    res_o.status        = status_q;
    res_o.entry_count   = cnt_out_x[CNT_OUT_W-1:0];
    res_o.is_empty_flag = (count_q == '0);
  end

endmodule

// File: design/double_ended_queue_buffer.sv
// Top level of the double-ended queue buffer.
// Depends on deqb_pkg, deqb_ctrl and deqb_ram.
//
// Usage:
//   A request is taken on a rising edge where start is high and busy is low.
//   It carries req_type, data_in, index_a and index_b in req_i. Every request
//   gives exactly one result on res_o, valid for the single cycle in which
//   done_o is high; the receiver must take it then, it cannot stall.
//   Push, pops, peek, read and unknown codes: result in the cycle after the
//   transfer; no new request is taken until that result cycle has ended.
//   A swap that goes ahead runs in steps: read A, read B, write A, write B,
//   with the result shown in the last write cycle. Swap rejected for empty
//   or range goes straight to the result state.
//   The entry RAM has a single read and a single write port, and its read
//   data is registered.
//   busy stays high from the transfer until the result cycle ends.
//   Reset clears the oldest pointer and the count; the entry RAM is not
//   cleared, entries are only read inside the held range.
module double_ended_queue_buffer #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  deqb_pkg::req_t req_i,
  output logic           done_o,
  output deqb_pkg::res_t res_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic                  we, re;
  logic [PW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  deqb_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .re_o    (re),
    .raddr_o (raddr),
    .rdata_i (rdata)
  );

  deqb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// File: design/deqb_checker.sv
// Port-level checker for the double-ended queue buffer, bound to the top.
// Depends on deqb_pkg.
module deqb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input deqb_pkg::res_t res_o
);
  import deqb_pkg::*;

  // a transfer always makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("no busy after transfer");

  // results only appear for a request in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result without request");

  // one result per request, then back to idle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy) else $error("extra result or stuck busy");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status == ST_EMPTY |-> res_o.is_empty_flag &&
    res_o.entry_count == '0) else $error("empty status with entries held");

endmodule

bind double_ended_queue_buffer deqb_checker u_deqb_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for double_ended_queue_buffer: directed table, then random requests,
// every result checked against its table entry or a shadow ring-buffer model.
// Depends on deqb_pkg and the design files.
module tb;
  import deqb_pkg::*;

  localparam int unsigned DEQ_DEPTH  = 16;
  localparam int unsigned RAND_ITEMS = 1000;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic [REQ_W-1:0] REQ_UNUSED6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED7 = 3'd7;

  typedef struct packed {
    req_t             req;
    logic [4:0]       reps;
    logic             typed;
    res_t             want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  res_t res_o;

  double_ended_queue_buffer #(
    .DEPTH(16),
    .DATA_WIDTH(32)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  // shadow deque
  logic [FIELD_DW-1:0] shadow_mem [DEQ_DEPTH];
  logic [3:0]          head_pos;
  logic [4:0]          fill;

  // expected results in transfer order
  res_t       due_res_q [64];
  logic [5:0] due_wr;
  logic [5:0] due_rd;
  dir_row_t   dir_rows  [64];
  logic [5:0] dir_cnt;
  res_t       due_res;
  int         err_cnt;
  int         cycle_cnt;
  int         burst_left;
  bit         fill_mode;

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic res_t deq_predict(req_t r);
    res_t       o;
    logic [3:0] sa;
    logic [3:0] sb;
    logic [FIELD_DW-1:0] tmp;
    o = '0;
    o.status = ST_OK;
    case (r.req_type) inside
      REQ_PUSH: begin
        if (fill >= 5'(DEQ_DEPTH)) begin
          o.status = ST_FULL;
        end else begin
          sa = head_pos + fill[3:0];
          shadow_mem[sa] = r.data_in;
          fill = fill + 5'd1;
        end
      end
      REQ_POP_OLD: begin
        if (fill == 5'd0) begin
          o.status = ST_EMPTY;
        end else begin
          o.data_out = shadow_mem[head_pos];
          head_pos = head_pos + 4'd1;
          fill = fill - 5'd1;
        end
      end
      REQ_POP_NEW, REQ_PEEK_NEW: begin
        if (fill == 5'd0) begin
          o.status = ST_EMPTY;
        end else begin
          sa = head_pos + fill[3:0] - 4'd1;
          o.data_out = shadow_mem[sa];
          if (r.req_type == REQ_POP_NEW) fill = fill - 5'd1;
        end
      end
      REQ_READ: begin
        if (fill == 5'd0) begin
          o.status = ST_EMPTY;
        end else if ({1'b0, r.index_a} >= fill) begin
          o.status = ST_RANGE;
        end else begin
          sa = head_pos + r.index_a;
          o.data_out = shadow_mem[sa];
        end
      end
      REQ_SWAP: begin
        if (fill == 5'd0) begin
          o.status = ST_EMPTY;
        end else if ({1'b0, r.index_a} >= fill || {1'b0, r.index_b} >= fill) begin
          o.status = ST_RANGE;
        end else begin
          sa = head_pos + r.index_a;
          sb = head_pos + r.index_b;
          tmp = shadow_mem[sa];
          shadow_mem[sa] = shadow_mem[sb];
          shadow_mem[sb] = tmp;
        end
      end
      default: ;
    endcase
    o.entry_count   = fill;
    o.is_empty_flag = (fill == 5'd0);
    return o;
  endfunction

  function automatic req_t mk_req(logic [REQ_W-1:0] op, logic [31:0] d,
                                  int ia, int ib);
    req_t r;
    r.req_type = op;
    r.data_in  = d;
    r.index_a  = 4'(ia);
    r.index_b  = 4'(ib);
    return r;
  endfunction

  function automatic res_t mk_res(logic [31:0] d, logic [STAT_W-1:0] st,
                                  int cnt, int emp);
    res_t o;
    o.data_out      = d;
    o.status        = st;
    o.entry_count   = 5'(cnt);
    o.is_empty_flag = (emp != 0);
    return o;
  endfunction

  task automatic add_row(req_t r, int reps, int typed, res_t want);
    dir_row_t row;
    row.req   = r;
    row.reps  = reps[4:0];
    row.typed = (typed != 0);
    row.want  = (typed != 0) ? want : '0;
    dir_rows[dir_cnt] = row;
    dir_cnt = dir_cnt + 6'd1;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  // one request transfer; the sender idles between bursts
  task automatic send_req(req_t r, bit typed, res_t want);
    res_t pred;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pred = deq_predict(r);
    due_res_q[due_wr] = typed ? want : pred;
    due_wr = due_wr + 6'd1;
  endtask

  function automatic logic [3:0] pick_index();
    if (fill != 5'd0 && $urandom_range(0, 3) != 0)
      return 4'($urandom_range(0, 32'(fill) - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  initial begin
    logic [REQ_W-1:0] op;
    int k;
    int pw;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    head_pos   = '0;
    fill       = '0;
    err_cnt    = 0;
    burst_left = 0;
    fill_mode  = 1'b1;
    due_wr     = '0;
    due_rd     = '0;
    dir_cnt    = '0;
    for (int i = 0; i < DEQ_DEPTH; i++) shadow_mem[i] = '0;

    add_row(mk_req(REQ_POP_OLD,  0, 0, 0), 1, 1, mk_res(0, ST_EMPTY, 0, 1));
    add_row(mk_req(REQ_POP_NEW,  0, 0, 0), 1, 1, mk_res(0, ST_EMPTY, 0, 1));
    add_row(mk_req(REQ_PEEK_NEW, 0, 0, 0), 1, 1, mk_res(0, ST_EMPTY, 0, 1));
    add_row(mk_req(REQ_READ,     0, 0, 0), 1, 1, mk_res(0, ST_EMPTY, 0, 1));
    add_row(mk_req(REQ_SWAP,     0, 0, 0), 1, 1, mk_res(0, ST_EMPTY, 0, 1));
    add_row(mk_req(REQ_UNUSED6, 32'hFFFF_FFFF, 15, 15), 1, 1, mk_res(0, ST_OK, 0, 1));
    add_row(mk_req(REQ_UNUSED7, 0, 0, 0), 1, 1, mk_res(0, ST_OK, 0, 1));
    add_row(mk_req(REQ_PUSH, 32'h7FFF_FFFF, 0, 0), 1, 1, mk_res(0, ST_OK, 1, 0));
    add_row(mk_req(REQ_PUSH, 32'h8000_0000, 0, 0), 1, 1, mk_res(0, ST_OK, 2, 0));
    add_row(mk_req(REQ_PEEK_NEW, 0, 0, 0), 1, 1, mk_res(32'h8000_0000, ST_OK, 2, 0));
    add_row(mk_req(REQ_READ, 0, 0, 0), 1, 1, mk_res(32'h7FFF_FFFF, ST_OK, 2, 0));
    add_row(mk_req(REQ_READ, 0, 15, 0), 1, 1, mk_res(0, ST_RANGE, 2, 0));
    add_row(mk_req(REQ_SWAP, 0, 0, 1), 1, 1, mk_res(0, ST_OK, 2, 0));
    add_row(mk_req(REQ_SWAP, 0, 1, 15), 1, 1, mk_res(0, ST_RANGE, 2, 0));
    add_row(mk_req(REQ_SWAP, 0, 1, 1), 1, 1, mk_res(0, ST_OK, 2, 0));
    add_row(mk_req(REQ_READ, 0, 0, 0), 1, 1, mk_res(32'h8000_0000, ST_OK, 2, 0));
    add_row(mk_req(REQ_POP_OLD, 0, 0, 0), 1, 1, mk_res(32'h8000_0000, ST_OK, 1, 0));
    add_row(mk_req(REQ_POP_NEW, 0, 0, 0), 1, 1, mk_res(32'h7FFF_FFFF, ST_OK, 0, 1));
    add_row(mk_req(REQ_PUSH, 32'hFFFF_FFFF, 0, 0), 16, 0, '0);
    add_row(mk_req(REQ_PUSH, 0, 0, 0), 1, 1, mk_res(0, ST_FULL, 16, 0));
    add_row(mk_req(REQ_READ, 0, 15, 0), 1, 1, mk_res(32'hFFFF_FFFF, ST_OK, 16, 0));
    add_row(mk_req(REQ_SWAP, 0, 0, 15), 1, 0, '0);
    add_row(mk_req(REQ_PEEK_NEW, 0, 0, 0), 1, 0, '0);
    add_row(mk_req(REQ_POP_OLD, 0, 0, 0), 16, 0, '0);
    add_row(mk_req(REQ_POP_OLD, 0, 0, 0), 1, 1, mk_res(0, ST_EMPTY, 0, 1));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < int'(dir_cnt); i++) begin
      repeat (dir_rows[6'(i)].reps)
        send_req(dir_rows[6'(i)].req, dir_rows[6'(i)].typed, dir_rows[6'(i)].want);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (fill == 5'(DEQ_DEPTH)) fill_mode = 1'b0;
      else if (fill == 5'd0) fill_mode = 1'b1;
      else if ($urandom_range(0, 63) == 0) fill_mode = !fill_mode;
      pw = fill_mode ? 50 : 15;
      k  = $urandom_range(0, 99);
      if (k < 2) op = $urandom_range(0, 1) ? REQ_UNUSED7 : REQ_UNUSED6;
      else if (k < 2 + pw) op = REQ_PUSH;
      else op = REQ_POP_OLD + 3'($urandom_range(0, 4));
      send_req(mk_req(op, $urandom(), int'(pick_index()), int'(pick_index())), 1'b0, '0);
    end
    start <= 1'b0;

    while (due_wr != due_rd) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (due_wr == due_rd) begin
        report_mismatch("result with nothing pending", res_o.data_out, 0);
      end else begin
        due_res = due_res_q[due_rd];
        due_rd  = due_rd + 6'd1;
        if (res_o.data_out !== due_res.data_out)
          report_mismatch("data_out", res_o.data_out, due_res.data_out);
        if (res_o.status !== due_res.status)
          report_mismatch("status", 32'(res_o.status), 32'(due_res.status));
        if (res_o.entry_count !== due_res.entry_count)
          report_mismatch("entry_count", 32'(res_o.entry_count), 32'(due_res.entry_count));
        if (res_o.is_empty_flag !== due_res.is_empty_flag)
          report_mismatch("is_empty_flag", 32'(res_o.is_empty_flag),
                          32'(due_res.is_empty_flag));
      end
    end
  end

endmodule

// File: filelist.f
design/deqb_pkg.sv
design/deqb_ram.sv
design/deqb_ctrl.sv
design/double_ended_queue_buffer.sv
design/deqb_checker.sv
tb/tb.sv
